[rtl/battery_gauge_colour_defines.svh]
// assertion macros shared by the battery gauge checker
// no dependencies; include guard below keeps it single-pass
`ifndef BATTERY_GAUGE_COLOUR_DEFINES_SVH
`define BATTERY_GAUGE_COLOUR_DEFINES_SVH

// clocked property, disabled while reset is low
`define BGC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("battery gauge assertion failed");

// same, with a caller-supplied message string
`define BGC_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

[rtl/bgc_pkg.sv]
// constants, discharge curve and codes for the battery gauge
// no dependencies; imported by every rtl module and interface of the block
`timescale 1ns / 1ps

package bgc_pkg;

  // field widths
  localparam int PinW   = 12;
  localparam int OhmW   = 22;
  localparam int CellW  = 16;
  localparam int PctW   = 7;
  localparam int ColW   = 2;
  localparam int ProdW  = PinW + OhmW;
  localparam int StepW  = $clog2(ProdW + 1);
  localparam int CntW   = $clog2(PinW + 1);

  // interpolation product: cell delta times percent span
  localparam int InterpW     = CellW + PctW;
  localparam int InterpShift = ProdW - InterpW;

  // discharge curve, highest voltage first
  localparam int CurvePoints = 21;
  localparam int CurveIdxW   = $clog2(CurvePoints);

  localparam logic [CellW-1:0] CurveMv [CurvePoints] = '{
    16'd4200, 16'd4150, 16'd4110, 16'd4080, 16'd4020, 16'd3980, 16'd3950,
    16'd3910, 16'd3870, 16'd3850, 16'd3840, 16'd3820, 16'd3800, 16'd3790,
    16'd3770, 16'd3750, 16'd3730, 16'd3710, 16'd3690, 16'd3610, 16'd3270
  };
  localparam logic [PctW-1:0] CurvePc [CurvePoints] = '{
    7'd100, 7'd95, 7'd90, 7'd85, 7'd80, 7'd75, 7'd70,
    7'd65,  7'd60, 7'd55, 7'd50, 7'd45, 7'd40, 7'd35,
    7'd30,  7'd25, 7'd20, 7'd15, 7'd10, 7'd5,  7'd0
  };

  // colour codes
  localparam logic [ColW-1:0] ColGreen  = 2'd0;
  localparam logic [ColW-1:0] ColYellow = 2'd1;
  localparam logic [ColW-1:0] ColRed    = 2'd2;

  // shown colour: none yet, else colour code plus one
  localparam logic [ColW-1:0] ShownNone   = 2'd0;
  localparam logic [ColW-1:0] ShownGreen  = 2'd1;
  localparam logic [ColW-1:0] ShownYellow = 2'd2;
  localparam logic [ColW-1:0] ShownRed    = 2'd3;

  // register indexes
  localparam logic [2:0] RegGreen  = 3'd0;
  localparam logic [2:0] RegYellow = 3'd1;
  localparam logic [2:0] RegHyst   = 3'd2;
  localparam logic [2:0] RegFull   = 3'd3;
  localparam logic [2:0] RegOutput = 3'd4;

endpackage

[rtl/bgc_in_if.sv]
// input channel of the battery gauge: one adc reading per beat
// depends on bgc_pkg for field widths
`timescale 1ns / 1ps

interface bgc_in_if import bgc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PinW-1:0] pin_mv;
  logic            sample_failed;

  modport source (output valid, pin_mv, sample_failed, input ready);
  modport sink   (input valid, pin_mv, sample_failed, output ready);
endinterface

[rtl/bgc_out_if.sv]
// result channel of the battery gauge: voltage, percent and colour per beat
// depends on bgc_pkg for field widths
`timescale 1ns / 1ps

interface bgc_out_if import bgc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CellW-1:0] cell_mv;
  logic [PctW-1:0]  charge_percent;
  logic [ColW-1:0]  colour;
  logic             colour_changed;
  logic             battery_low;

  modport source (output valid, cell_mv, charge_percent, colour, colour_changed,
                  battery_low, input ready);
  modport sink   (input valid, cell_mv, charge_percent, colour, colour_changed,
                  battery_low, output ready);
endinterface

[rtl/battery_gauge_colour.sv]
// top level of the battery gauge: apb registers, sequencer and result register
// depends on bgc_pkg, bgc_in_if, bgc_out_if, bgc_mul and bgc_div
`timescale 1ns / 1ps

// Battery gauge: each accepted good reading yields one result beat holding the
// cell voltage (pin_mv * full / output ohms, low 16 bits), the percent from a
// 21-point discharge curve and a green/yellow/red colour with upward hysteresis.
// A failed reading is accepted and dropped; the sequencer stays in idle. A good
// reading runs through the bit-serial multiplier (12 steps), the bit-serial
// divider (34 steps) and a search that walks the curve points from the top;
// when the voltage lands between two points, a multiply and a 23-step divide
// interpolate the percent. Then the result register is loaded and the sequencer
// goes back to idle, where the next reading is let in. The divider's
// one-bit-per-cycle loop sets most of the time a good reading takes. A new reading
// is taken once the sequencer is back in idle, even while the previous result
// still waits in the output register; a result that finds the register still
// full holds the sequencer until that beat leaves.
// Registers sit at byte addresses 0, 4, 8, 12 and 16; pready is always high.

module battery_gauge_colour import bgc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  bgc_in_if.sink      in_i,
  bgc_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StSrch = 3'd3;
  localparam logic [2:0] StIMul = 3'd4;
  localparam logic [2:0] StIDiv = 3'd5;
  localparam logic [2:0] StDone = 3'd6;

  logic [PctW-1:0]      green_q, yellow_q, hyst_q;
  logic [OhmW-1:0]      full_q, outohm_q;
  logic [2:0]           state_q, state_d;
  logic [CellW-1:0]     cell_q;
  logic [PctW-1:0]      pc_q;
  logic [CurveIdxW-1:0] idx_q;
  logic [ColW-1:0]      shown_q;
  logic                 out_valid_q;
  logic [CellW-1:0]     out_cell_q;
  logic [PctW-1:0]      out_pc_q;
  logic [ColW-1:0]      out_col_q;
  logic                 out_chg_q, out_low_q;

  logic                 cfg_wr;
  logic [2:0]           reg_idx;
  logic                 in_acc, out_load;
  logic                 mul_start, mul_busy;
  logic [OhmW-1:0]      mul_a;
  logic [PinW-1:0]      mul_b;
  logic [ProdW-1:0]     mul_prod;
  logic                 div_start, div_busy;
  logic [ProdW-1:0]     div_num, div_quot;
  logic [OhmW-1:0]      div_den;
  logic [StepW-1:0]     div_steps;
  logic [CurveIdxW-1:0] idx_prev;
  logic [CellW-1:0]     lo_mv, span_mv, delta_mv;
  logic [PctW-1:0]      span_pc;
  logic                 pt_ge;
  logic [PctW:0]        pc_x, g_x, y_x, gh, yh;
  logic [ColW-1:0]      col, col_p1;

  // apb register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      green_q  <= PctW'(50);
      yellow_q <= PctW'(20);
      hyst_q   <= PctW'(5);
      full_q   <= OhmW'(139300);
      outohm_q <= OhmW'(100000);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegGreen:  green_q  <= pwdata[PctW-1:0];
        RegYellow: yellow_q <= pwdata[PctW-1:0];
        RegHyst:   hyst_q   <= pwdata[PctW-1:0];
        RegFull:   full_q   <= pwdata[OhmW-1:0];
        RegOutput: outohm_q <= pwdata[OhmW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegGreen:  prdata = {{(32 - PctW){1'b0}}, green_q};
      RegYellow: prdata = {{(32 - PctW){1'b0}}, yellow_q};
      RegHyst:   prdata = {{(32 - PctW){1'b0}}, hyst_q};
      RegFull:   prdata = {{(32 - OhmW){1'b0}}, full_q};
      RegOutput: prdata = {{(32 - OhmW){1'b0}}, outohm_q};
      default:   prdata = '0;
    endcase
  end

  // handshakes
  assign in_i.ready = (state_q == StIdle);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_load   = (state_q == StDone) && (!out_valid_q || out_o.ready);

  // curve points around the search index
  assign idx_prev = idx_q - 1'b1;
  assign lo_mv    = CurveMv[idx_q];
  assign span_mv  = CurveMv[idx_prev] - lo_mv;
  assign span_pc  = CurvePc[idx_prev] - CurvePc[idx_q];
  assign delta_mv = cell_q - lo_mv;
  assign pt_ge    = (cell_q >= lo_mv);

  // serial units
  bgc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .prod_o  (mul_prod)
  );

  bgc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .steps_i    (div_steps),
    .busy_o     (div_busy),
    .quotient_o (div_quot)
  );

  // sequencer
  always_comb begin
    state_d   = state_q;
    mul_start = 1'b0;
    mul_a     = full_q;
    mul_b     = in_i.pin_mv;
    div_start = 1'b0;
    div_num   = mul_prod;
    div_den   = outohm_q;
    div_steps = StepW'(ProdW);
    unique case (state_q)
      StIdle: begin
        if (in_acc && !in_i.sample_failed) begin
          mul_start = 1'b1;
          state_d   = StMul;
        end
      end
      StMul: begin
        if (!mul_busy) begin
          div_start = 1'b1;
          state_d   = StDiv;
        end
      end
      StDiv: begin
        if (!div_busy) begin
          state_d = StSrch;
        end
      end
      StSrch: begin
        mul_a = {{(OhmW - CellW){1'b0}}, delta_mv};
        mul_b = {{(PinW - PctW){1'b0}}, span_pc};
        if (pt_ge) begin
          if (idx_q == '0 || span_mv == '0) begin
            state_d = StDone;
          end else begin
            mul_start = 1'b1;
            state_d   = StIMul;
          end
        end else if (idx_q == CurveIdxW'(CurvePoints - 1)) begin
          state_d = StDone;
        end
      end
      StIMul: begin
        div_num   = {mul_prod[InterpW-1:0], {InterpShift{1'b0}}};
        div_den   = {{(OhmW - CellW){1'b0}}, span_mv};
        div_steps = StepW'(InterpW);
        if (!mul_busy) begin
          div_start = 1'b1;
          state_d   = StIDiv;
        end
      end
      StIDiv: begin
        if (!div_busy) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // cell voltage, search index and percent
  always_ff @(posedge clk_i) begin
    if (state_q == StDiv && !div_busy) begin
      cell_q <= div_quot[CellW-1:0];
      idx_q  <= '0;
    end
    if (state_q == StSrch) begin
      if (pt_ge) begin
        if (idx_q == '0) begin
          pc_q <= CurvePc[0];
        end else if (span_mv == '0) begin
          pc_q <= CurvePc[idx_q];
        end
      end else if (idx_q == CurveIdxW'(CurvePoints - 1)) begin
        pc_q <= '0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
    if (state_q == StIDiv && !div_busy) begin
      pc_q <= CurvePc[idx_q] + div_quot[PctW-1:0];
    end
  end

  // colour choice with upward hysteresis
  always_comb begin
    pc_x = {1'b0, pc_q};
    g_x  = {1'b0, green_q};
    y_x  = {1'b0, yellow_q};
    gh   = g_x + {1'b0, hyst_q};
    yh   = y_x + {1'b0, hyst_q};
    unique case (shown_q)
      ShownGreen: begin
        if (pc_x < g_x) col = (pc_x < y_x) ? ColRed : ColYellow;
        else            col = ColGreen;
      end
      ShownYellow: begin
        if (pc_x >= gh) col = ColGreen;
        else            col = (pc_x < y_x) ? ColRed : ColYellow;
      end
      ShownRed: begin
        if (pc_x >= gh) col = ColGreen;
        else            col = (pc_x >= yh) ? ColYellow : ColRed;
      end
      ShownNone: begin
        if (pc_x >= g_x) col = ColGreen;
        else             col = (pc_x >= y_x) ? ColYellow : ColRed;
      end
    endcase
    col_p1 = col + 1'b1;
  end

  // shown colour and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shown_q     <= ShownNone;
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      shown_q     <= col_p1;
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result beat payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_cell_q <= cell_q;
      out_pc_q   <= pc_q;
      out_col_q  <= col;
      out_chg_q  <= (col_p1 != shown_q);
      out_low_q  <= (pc_x < y_x);
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.cell_mv        = out_cell_q;
  assign out_o.charge_percent = out_pc_q;
  assign out_o.colour         = out_col_q;
  assign out_o.colour_changed = out_chg_q;
  assign out_o.battery_low    = out_low_q;

endmodule

[rtl/bgc_mul.sv]
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on bgc_pkg for operand widths
`timescale 1ns / 1ps

module bgc_mul import bgc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [OhmW-1:0]  a_i,
  input  logic [PinW-1:0]  b_i,
  output logic             busy_o,
  output logic [ProdW-1:0] prod_o
);

  logic [ProdW:0]    acc_q, acc_d;
  logic [OhmW-1:0]   a_q;
  logic [CntW-1:0]   cnt_q;
  logic [OhmW:0]     sum;

  // add multiplicand into upper half when the low bit is set, then shift right
  always_comb begin
    sum   = {1'b0, acc_q[ProdW-1:PinW]} + (acc_q[0] ? {1'b0, a_q} : '0);
    acc_d = {1'b0, sum, acc_q[PinW-1:1]};
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(PinW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // accumulator and multiplicand
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= {{(OhmW + 1){1'b0}}, b_i};
      a_q   <= a_i;
    end else if (cnt_q != '0) begin
      acc_q <= acc_d;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign prod_o = acc_q[ProdW-1:0];

endmodule

[rtl/bgc_div.sv]
// bit-serial restoring divider, one quotient bit per cycle, msb first
// depends on bgc_pkg for operand widths; a zero divisor gives a one for every quotient bit
`timescale 1ns / 1ps

module bgc_div import bgc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ProdW-1:0] dividend_i,
  input  logic [OhmW-1:0]  divisor_i,
  input  logic [StepW-1:0] steps_i,
  output logic             busy_o,
  output logic [ProdW-1:0] quotient_o
);

  logic [ProdW-1:0] num_q, num_d;
  logic [OhmW-1:0]  rem_q, rem_d;
  logic [OhmW-1:0]  div_q;
  logic [StepW-1:0] cnt_q;
  logic [OhmW:0]    shl, diff;
  logic             ge;

  // shift in next dividend bit, subtract when it fits
  always_comb begin
    shl   = {rem_q, num_q[ProdW-1]};
    ge    = (shl >= {1'b0, div_q});
    diff  = shl - {1'b0, div_q};
    rem_d = ge ? diff[OhmW-1:0] : shl[OhmW-1:0];
    num_d = {num_q[ProdW-2:0], ge};
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= steps_i;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // dividend becomes quotient as it shifts through
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (cnt_q != '0) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = num_q;

endmodule

[rtl/bgc_checker.sv]
// port-level checks on the battery gauge result channel, bound to the top level
// depends on bgc_pkg and battery_gauge_colour_defines.svh
`timescale 1ns / 1ps
`include "battery_gauge_colour_defines.svh"

module bgc_checker import bgc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [CellW-1:0] cell_mv_i,
  input logic [PctW-1:0]  charge_percent_i,
  input logic [ColW-1:0]  colour_i
);

  logic [CellW+PctW+ColW-1:0] beat;

  // watched payload of the result beat
  assign beat = {cell_mv_i, charge_percent_i, colour_i};

  // a stalled beat keeps its payload
  `BGC_ASSERT(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(beat))

  // only green, yellow or red leave the block
  `BGC_ASSERT_MSG(a_colour, clk_i, rst_ni, out_valid_i |-> colour_i <= ColRed, "bad colour code")

  // percent never exceeds the top of the curve
  `BGC_ASSERT(a_pct, clk_i, rst_ni, out_valid_i |-> charge_percent_i <= CurvePc[0])

endmodule

bind battery_gauge_colour bgc_checker u_bgc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .cell_mv_i        (out_o.cell_mv),
  .charge_percent_i (out_o.charge_percent),
  .colour_i         (out_o.colour)
);

[tb/sv/bgc_gauge_check.sv]
// watches the reading, result and register ports of the battery gauge and predicts each result
// depends on bgc_pkg, bgc_in_if and bgc_out_if
`timescale 1ns / 1ps

module bgc_gauge_check import bgc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  bgc_in_if           in_mon_i,
  bgc_out_if          out_mon_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  // register values after reset
  localparam logic [PctW-1:0] GreenInit  = 7'd50;
  localparam logic [PctW-1:0] YellowInit = 7'd20;
  localparam logic [PctW-1:0] HystInit   = 7'd5;
  localparam logic [OhmW-1:0] FullInit   = 22'd139300;
  localparam logic [OhmW-1:0] OutputInit = 22'd100000;

  typedef struct packed {
    logic [CellW-1:0] cell_mv;
    logic [PctW-1:0]  charge_percent;
    logic [ColW-1:0]  colour;
    logic             colour_changed;
    logic             battery_low;
  } gauge_res_t;

  logic [PctW-1:0] green_thr;
  logic [PctW-1:0] yellow_thr;
  logic [PctW-1:0] hyst_margin;
  logic [OhmW-1:0] full_res;
  logic [OhmW-1:0] out_ohms;
  logic [ColW-1:0] shown_colour;

  gauge_res_t  pending_readings [$];
  gauge_res_t  want;
  gauge_res_t  got;
  int unsigned mismatches;

  // linear interpolation over the discharge curve, clamped at both ends
  function automatic int unsigned percent_of(input logic [CellW-1:0] mv);
    int unsigned span_mv;
    int unsigned span_pc;
    int unsigned pct;
    pct = 0;
    if (mv >= CurveMv[0]) begin
      pct = 32'(CurvePc[0]);
    end else begin
      for (int k = CurvePoints - 1; k >= 1; k--) begin
        // scan from the bottom so the last hit is the first segment from the top
        if (mv >= CurveMv[k]) begin
          span_mv = 32'(CurveMv[k-1]) - 32'(CurveMv[k]);
          span_pc = 32'(CurvePc[k-1]) - 32'(CurvePc[k]);
          if (span_mv == 0) pct = 32'(CurvePc[k]);
          else pct = (32'(CurvePc[k]) + (32'(mv - CurveMv[k]) * span_pc) / span_mv) & 32'h7F;
        end
      end
    end
    return pct;
  endfunction

  // colour falls at once, steps up only past threshold plus margin
  function automatic logic [ColW-1:0] next_colour(input int unsigned pc,
                                                  input logic [ColW-1:0] prev);
    int unsigned g;
    int unsigned y;
    int unsigned h;
    logic [ColW-1:0] pick;
    g = 32'(green_thr);
    y = 32'(yellow_thr);
    h = 32'(hyst_margin);
    case (prev)
      ShownGreen: begin
        if (pc >= g) pick = ColGreen;
        else pick = (pc < y) ? ColRed : ColYellow;
      end
      ShownYellow: begin
        if (pc >= g + h) pick = ColGreen;
        else pick = (pc < y) ? ColRed : ColYellow;
      end
      ShownRed: begin
        if (pc >= g + h) pick = ColGreen;
        else pick = (pc >= y + h) ? ColYellow : ColRed;
      end
      default: begin
        if (pc >= g) pick = ColGreen;
        else pick = (pc >= y) ? ColYellow : ColRed;
      end
    endcase
    return pick;
  endfunction

  // full result of one good reading under the current registers
  function automatic gauge_res_t gauge_reading(input logic [PinW-1:0] pin);
    gauge_res_t  r;
    logic [63:0] quot;
    int unsigned pc;
    if (out_ohms == '0) quot = '1;
    else quot = (64'(pin) * 64'(full_res)) / 64'(out_ohms);
    r.cell_mv        = quot[CellW-1:0];
    pc               = percent_of(r.cell_mv);
    r.charge_percent = pc[PctW-1:0];
    r.colour         = next_colour(pc, shown_colour);
    r.colour_changed = ((r.colour + 2'd1) != shown_colour);
    r.battery_low    = (pc < 32'(yellow_thr));
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      green_thr    = GreenInit;
      yellow_thr   = YellowInit;
      hyst_margin  = HystInit;
      full_res     = FullInit;
      out_ohms     = OutputInit;
      shown_colour = ShownNone;
      mismatches   = 0;
      pending_readings.delete();
    end else begin
      // register writes at the access edge
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          RegGreen:  green_thr   = pwdata[PctW-1:0];
          RegYellow: yellow_thr  = pwdata[PctW-1:0];
          RegHyst:   hyst_margin = pwdata[PctW-1:0];
          RegFull:   full_res    = pwdata[OhmW-1:0];
          RegOutput: out_ohms    = pwdata[OhmW-1:0];
          default: ;
        endcase
      end

      // result beat against the oldest prediction
      if (out_mon_i.valid && out_mon_i.ready) begin
        got.cell_mv        = out_mon_i.cell_mv;
        got.charge_percent = out_mon_i.charge_percent;
        got.colour         = out_mon_i.colour;
        got.colour_changed = out_mon_i.colour_changed;
        got.battery_low    = out_mon_i.battery_low;
        if (pending_readings.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result beat with no reading pending: cell %0d pct %0d col %0d",
                     $time, got.cell_mv, got.charge_percent, got.colour);
          mismatches++;
        end else begin
          want = pending_readings.pop_front();
          if (got.cell_mv !== want.cell_mv ||
              got.charge_percent !== want.charge_percent ||
              got.colour !== want.colour ||
              got.colour_changed !== want.colour_changed ||
              got.battery_low !== want.battery_low) begin
            if (mismatches < 10)
              $display("%0t: mismatch, expected cell %0d pct %0d col %0d chg %0b low %0b, %s",
                       $time, want.cell_mv, want.charge_percent, want.colour,
                       want.colour_changed, want.battery_low,
                       $sformatf("got cell %0d pct %0d col %0d chg %0b low %0b",
                                 got.cell_mv, got.charge_percent, got.colour,
                                 got.colour_changed, got.battery_low));
            mismatches++;
          end
        end
      end

      // reading beat: failed samples leave no trace
      if (in_mon_i.valid && in_mon_i.ready && !in_mon_i.sample_failed) begin
        want = gauge_reading(in_mon_i.pin_mv);
        shown_colour = want.colour + 2'd1;
        pending_readings.push_back(want);
      end
    end
    pending_o    <= pending_readings.size();
    fail_count_o <= mismatches;
  end

endmodule

[tb/sv/tb.sv]
// top of the battery gauge testbench: clock, reset, register writes and reading stimulus
// depends on bgc_pkg, the channel interfaces, battery_gauge_colour and bgc_gauge_check
`timescale 1ns / 1ps

module tb import bgc_pkg::*;;

  // indexes past the last register, writes there are dropped
  localparam logic [2:0] RegPastLast = RegOutput + 3'd1;
  localparam logic [2:0] RegTopIdx   = 3'd7;

  typedef enum int {RxOpen, RxMostly, RxSparse, RxPulse} rx_mode_e;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned fail_count;
  int unsigned pending;
  logic        hold_rx = 1'b0;
  logic        squeeze_go = 1'b0;
  logic        offering = 1'b0;
  int          burst_left = 0;

  bgc_in_if  in_ch ();
  bgc_out_if out_ch ();

  battery_gauge_colour i_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bgc_gauge_check i_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_mon_i     (in_ch),
    .out_mon_i    (out_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // one apb write, junk above the register width now and then
  task automatic write_reg(input logic [2:0] idx, input int unsigned value);
    logic [31:0] data;
    data = value;
    if ($urandom_range(0, 3) == 0) begin
      if (idx == RegFull || idx == RegOutput) data = data | ($urandom() << OhmW);
      else data = data | ($urandom() << PctW);
    end
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_gauge(input int unsigned g, input int unsigned y, input int unsigned h,
                           input int unsigned full, input int unsigned outr);
    write_reg(RegGreen, g);
    write_reg(RegYellow, y);
    write_reg(RegHyst, h);
    write_reg(RegFull, full);
    write_reg(RegOutput, outr);
    if ($urandom_range(0, 1) == 1) write_reg(RegPastLast, $urandom());
  endtask

  // offer one reading beat; bursts of random length, random gaps between
  task automatic offer_reading(input logic [PinW-1:0] pin, input logic failed);
    in_ch.valid         <= 1'b1;
    in_ch.pin_mv        <= pin;
    in_ch.sample_failed <= failed;
    offering = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      burst_left = $urandom_range(0, 40);
    end
  endtask

  // stop offering, let every result come out and the sequencer go idle
  task automatic settle();
    if (offering) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
    end
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // result receiver with a stall pattern of its own
  initial begin
    rx_mode_e mode;
    int       left;
    logic     rdy;
    out_ch.ready <= 1'b0;
    mode = RxOpen;
    left = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        left = $urandom_range(32, 400);
      end
      left--;
      case (mode)
        RxOpen:   rdy = 1'b1;
        RxMostly: rdy = ($urandom_range(0, 3) != 0);
        RxSparse: rdy = ($urandom_range(0, 3) == 0);
        default:  rdy = ((left % 8) < 3);
      endcase
      if (hold_rx) rdy = 1'b0;
      out_ch.ready <= rdy;
    end
  end

  // long receiver hold-off while readings keep coming
  initial begin
    wait (squeeze_go);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (3000) @(posedge clk);
    hold_rx <= 1'b0;
  end

  initial begin
    #6000000;
    $display("TB_ERROR");
    $finish;
  end

  // stimulus
  initial begin
    int unsigned g;
    int unsigned y;
    int unsigned h;
    int unsigned full_set;
    int unsigned out_set;
    int unsigned pick;
    int          n;
    int          good;
    int          walk_mv;
    longint      scaled;
    logic [PinW-1:0] pin;
    logic        failed;

    rst_n               <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.pin_mv        <= '0;
    in_ch.sample_failed <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ratio of two: cell voltage is twice the pin, so curve points are exact
    set_gauge(50, 20, 5, 2, 1);
    write_reg(RegTopIdx, $urandom());
    offer_reading(12'd0, 1'b0);       // first sample, red without hysteresis
    offer_reading(12'hFFF, 1'b1);     // failed sample
    offer_reading(12'hFFF, 1'b0);     // far above the top point
    offer_reading(12'd2100, 1'b0);    // on the top point
    offer_reading(12'd2099, 1'b0);    // just below the top point
    offer_reading(12'd1925, 1'b0);
    offer_reading(12'd1920, 1'b0);    // on the green threshold
    offer_reading(12'd1919, 1'b0);    // drop to yellow
    offer_reading(12'd1922, 1'b0);    // inside the margin, stays yellow
    offer_reading(12'd1925, 1'b0);    // clears the margin, back to green
    offer_reading(12'd1865, 1'b0);    // on the yellow threshold
    offer_reading(12'd1864, 1'b0);    // drop to red
    offer_reading(12'd1870, 1'b0);    // inside the margin, stays red
    offer_reading(12'd1875, 1'b0);    // clears the margin, yellow
    offer_reading(12'd1635, 1'b0);    // on the bottom point
    offer_reading(12'd1634, 1'b0);    // below the bottom point
    offer_reading(12'd0, 1'b1);
    offer_reading(12'd1805, 1'b0);
    settle();

    // zero output resistance
    set_gauge(50, 20, 5, 139300, 0);
    offer_reading(12'd100, 1'b0);
    offer_reading(12'd0, 1'b0);
    offer_reading(12'hABC, 1'b1);
    offer_reading(12'hFFF, 1'b0);
    settle();

    // random phases, extremes of the registers among them
    walk_mv = 3800;
    for (int p = 0; p < 9; p++) begin
      g        = $urandom_range(30, 70);
      y        = $urandom_range(5, 40);
      h        = $urandom_range(0, 10);
      out_set  = $urandom_range(1000, 400000);
      full_set = out_set + out_set * $urandom_range(0, 1000) / 1000;
      n        = 155;
      case (p)
        0: begin
          g = 50; y = 20; h = 5; full_set = 139300; out_set = 100000;
        end
        2: begin
          g = 100; y = 0; h = 0;
        end
        3: begin
          g = 127; y = 127; h = 127;
        end
        4: begin
          g = 0; y = 0; h = 100; full_set = 32'h3FFFFF; out_set = 1;
        end
        5: begin
          full_set = 32'h3FFFFF; out_set = 32'h3FFFFF;
        end
        6: begin
          out_set = 0; n = 60;
        end
        7: begin
          g = 10; y = 90; h = 20;
        end
        default: ;
      endcase
      set_gauge(g, y, h, full_set, out_set);
      if (p == 1) squeeze_go = 1'b1;

      good = 0;
      while (good < n) begin
        pick   = $urandom_range(0, 99);
        failed = 1'b0;
        if (pick < 8) begin
          failed = 1'b1;
          pin    = PinW'($urandom_range(0, 4095));
        end else if (pick < 22) begin
          pin = PinW'($urandom_range(0, 4095));
        end else if (pick < 26) begin
          pin = ($urandom_range(0, 1) == 1) ? 12'hFFF : 12'h000;
        end else begin
          // slow walk of the cell voltage across the curve
          if ($urandom_range(0, 15) == 0) walk_mv = $urandom_range(3150, 4350);
          else walk_mv = walk_mv + int'($urandom_range(0, 60)) - 30;
          if (walk_mv < 3150) walk_mv = 3150;
          if (walk_mv > 4350) walk_mv = 4350;
          if (full_set != 0 && out_set != 0) begin
            scaled = longint'(walk_mv) * longint'(out_set) / longint'(full_set);
            pin    = (scaled > 4095) ? 12'hFFF : scaled[PinW-1:0];
          end else begin
            pin = PinW'($urandom_range(0, 4095));
          end
        end
        offer_reading(pin, failed);
        if (!failed) good++;
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/bgc_pkg.sv
rtl/bgc_in_if.sv
rtl/bgc_out_if.sv
rtl/bgc_mul.sv
rtl/bgc_div.sv
rtl/battery_gauge_colour.sv
rtl/bgc_checker.sv
tb/sv/bgc_gauge_check.sv
tb/sv/tb.sv
